// ===== rtl/core/bfaq_pkg.sv =====
// Package for the bloom filter add/query block: sizes, register indexes,
// hash constants and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bfaq_pkg;
    localparam int MAX_BITS    = 65536;
    localparam int WORD_BITS   = 8;
    localparam int STORE_DEPTH = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BIT_W       = $clog2(MAX_BITS);
    localparam int BC_W        = 17;
    localparam int HR_W        = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_ROUNDS = 2'd1;

    localparam logic [31:0]     DJB2_START     = 32'd5381;
    localparam logic [BC_W-1:0] BC_RESET       = 17'd65536;
    localparam logic [HR_W-1:0] HR_RESET       = 6'd7;
    localparam logic            OP_ADD         = 1'b0;

    typedef struct packed {
        logic clr_en;      // write zero at the clear pointer, advance it
        logic hash_en;     // fold the accepted word into both hashes
        logic hash_clr;    // return hashes to their start values
        logic rounds_init; // round 0, multiple accumulator zero
        logic idx_load;    // form the round index, start the divider
        logic div_step;    // one restoring division step
        logic rd_en;       // read the store word of the current bit
        logic wr_en;       // write back the word with the bit set
        logic next_round;  // advance round counter and multiple
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic rounds_zero;
        logic round_last;
        logic bit_miss;
    } t_sts;
endpackage
`default_nettype wire

// ===== rtl/core/bfaq_datapath.sv =====
// Datapath: hash accumulators, config registers, round index, serial
// modulo unit and the filter store memory. Depends on bfaq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfaq_datapath (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire  bfaq_pkg::t_cmd              i_cmd,
    output bfaq_pkg::t_sts                    o_sts,
    input  wire  [7:0]                        i_data_byte,
    input  wire                               i_byte_valid,
    input  wire                               i_cfg_we,
    input  wire  [bfaq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [bfaq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bfaq_pkg::*;

    logic [BC_W-1:0]   r_bit_count;
    logic [HR_W-1:0]   r_hash_rounds;
    logic [31:0]       r_h1, r_h2, r_mul;
    logic [HR_W-1:0]   r_round;
    logic [31:0]       r_dvd;
    logic [BC_W-1:0]   r_rem;
    logic [4:0]        r_div_cnt;
    logic [ADDR_W-1:0] r_clr_ptr;
    logic [7:0]        r_rd_data;
    logic [7:0]        mem [STORE_DEPTH];

    logic [31:0]     c_ext, n_h1, n_h2, c_idx;
    logic [BC_W-1:0] c_bc;
    logic [BC_W:0]   c_trial, c_sub;
    logic [7:0]      c_mask;
    logic [ADDR_W-1:0] c_addr;

    always_comb begin
        c_ext = {{24{i_data_byte[7]}}, i_data_byte};
        n_h1  = (r_h1 << 5) + r_h1 + c_ext;
        n_h2  = c_ext + ((r_h2 << 6) + (r_h2 << 16) - r_h2);
        if (r_bit_count == '0) begin
            c_bc = BC_W'(1);
        end else if (r_bit_count > BC_W'(MAX_BITS)) begin
            c_bc = BC_W'(MAX_BITS);
        end else begin
            c_bc = r_bit_count;
        end
        if (r_round == '0) begin
            c_idx = r_h1;
        end else if (r_round == HR_W'(1)) begin
            c_idx = r_h2;
        end else begin
            c_idx = r_h1 + r_mul + {26'd0, r_round ^ HR_W'(2)};
        end
        c_trial = {r_rem, r_dvd[31]};
        c_sub   = c_trial - {1'b0, c_bc};
        c_mask  = 8'(1) << r_rem[2:0];
        c_addr  = r_rem[BIT_W-1:3];
    end

    assign o_sts.clr_last    = (r_clr_ptr == ADDR_W'(STORE_DEPTH - 1));
    assign o_sts.div_last    = (r_div_cnt == 5'd31);
    assign o_sts.rounds_zero = (r_hash_rounds == '0);
    assign o_sts.round_last  = ({1'b0, r_round} + 7'd1 == {1'b0, r_hash_rounds});
    assign o_sts.bit_miss    = ((r_rd_data & c_mask) == 8'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_count   <= BC_RESET;
            r_hash_rounds <= HR_RESET;
            r_h1          <= DJB2_START;
            r_h2          <= '0;
            r_clr_ptr     <= '0;
            r_div_cnt     <= '0;
            r_round       <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == REG_BIT_COUNT) begin
                r_bit_count <= i_cfg_data[BC_W-1:0];
            end
            if (i_cfg_we && i_cfg_index == REG_HASH_ROUNDS) begin
                r_hash_rounds <= i_cfg_data[HR_W-1:0];
            end
            if (i_cmd.hash_clr) begin
                r_h1 <= DJB2_START;
                r_h2 <= '0;
            end else if (i_cmd.hash_en && i_byte_valid) begin
                r_h1 <= n_h1;
                r_h2 <= n_h2;
            end
            if (i_cmd.clr_en) begin
                r_clr_ptr <= r_clr_ptr + ADDR_W'(1);
            end
            if (i_cmd.idx_load) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 5'd1;
            end
            if (i_cmd.rounds_init) begin
                r_round <= '0;
            end else if (i_cmd.next_round) begin
                r_round <= r_round + HR_W'(1);
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rounds_init) begin
            r_mul <= '0;
        end else if (i_cmd.next_round) begin
            r_mul <= r_mul + r_h2;
        end
        if (i_cmd.idx_load) begin
            r_dvd <= c_idx;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= c_sub[BC_W] ? c_trial[BC_W-1:0] : c_sub[BC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            mem[r_clr_ptr] <= 8'd0;
        end else if (i_cmd.wr_en) begin
            mem[c_addr] <= r_rd_data | c_mask;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[c_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/bfaq_ctrl.sv =====
// Controller: sequences clearing, hashing, per-round modulo and
// read-modify-write, and strobes the result. Depends on bfaq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bfaq_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_start,
    input  wire             i_opcode,
    input  wire             i_last,
    output logic            o_busy,
    output logic            o_done,
    output logic            o_done_op,
    output logic            o_present,
    output bfaq_pkg::t_cmd  o_cmd,
    input  wire  bfaq_pkg::t_sts i_sts
);
    import bfaq_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_IDX, S_DIV, S_RD, S_RMW} t_state;

    t_state r_state, n_state;
    logic   r_op, n_op, r_done, n_done, r_present, n_present;
    logic   c_accept;

    assign c_accept  = i_start && (r_state == S_IDLE);
    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = r_done;
    assign o_done_op = r_op;
    assign o_present = r_present;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_done    = 1'b0;
        n_present = r_present;
        o_cmd     = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (c_accept) begin
                    o_cmd.hash_en = 1'b1;
                    if (i_last) begin
                        n_op      = i_opcode;
                        n_present = 1'b1;
                        o_cmd.rounds_init = 1'b1;
                        if (i_sts.rounds_zero) begin
                            o_cmd.hash_clr = 1'b1;
                            n_done = 1'b1;
                        end else begin
                            n_state = S_IDX;
                        end
                    end
                end
            end
            S_IDX: begin
                o_cmd.idx_load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_RD;
            end
            S_RD: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_RMW;
            end
            S_RMW: begin
                o_cmd.wr_en = (r_op == OP_ADD);
                if (r_op != OP_ADD && i_sts.bit_miss) begin
                    n_present = 1'b0;
                    o_cmd.hash_clr = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_sts.round_last) begin
                    o_cmd.hash_clr = 1'b1;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.next_round = 1'b1;
                    n_state = S_IDX;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_done    <= 1'b0;
            r_op      <= 1'b0;
            r_present <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_op      <= n_op;
            r_present <= n_present;
        end
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("result strobe outside idle");
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_last) |=> r_state == S_DIV)
        else $error("divider left early");
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW && r_op != OP_ADD && i_sts.bit_miss) |=> (r_done && !r_present))
        else $error("query miss not reported");
    a_add_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_op == OP_ADD) |-> r_present) else $error("add reported absent");
endmodule
`default_nettype wire

// ===== rtl/core/bloom_filter_add_query_top.sv =====
// Top level of the bloom filter add/query block: controller plus datapath.
// Depends on bfaq_pkg, bfaq_ctrl and bfaq_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Usage: after reset the block clears all 8192 words of the filter store
// (o_busy high, config writes still taken). A word is taken when i_start is
// high and o_busy low. A non-last word is hashed and leaves the block idle.
// A last word runs hash_rounds rounds, each an index add, a 32-step serial
// modulo, a store read and a store write-back; a query stops at the first
// clear bit. The result strobes on o_done for exactly one cycle, in the
// cycle after the final write-back, and the receiver cannot stall it:
// sample o_done_op and o_present in that cycle. With zero rounds the result
// strobes in the cycle after the last word. Write config only while idle.
module bloom_filter_add_query_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    output logic                             o_busy,
    input  wire                              i_opcode,
    input  wire  [7:0]                       i_data_byte,
    input  wire                              i_byte_valid,
    input  wire                              i_last,
    output logic                             o_done,
    output logic                             o_done_op,
    output logic                             o_present,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [bfaq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [bfaq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bfaq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Config registers take a word in any cycle.
    assign o_cfg_ready = 1'b1;

    bfaq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_opcode  (i_opcode),
        .i_last    (i_last),
        .o_busy    (o_busy),
        .o_done    (o_done),
        .o_done_op (o_done_op),
        .o_present (o_present),
        .o_cmd     (cmd),
        .i_sts     (sts)
    );

    bfaq_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_data_byte  (i_data_byte),
        .i_byte_valid (i_byte_valid),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );
endmodule
`default_nettype wire
